### src/mrs_pkg.sv
// mrs_pkg: sizes, function codes, sequencer states and the crc step
// of the modbus rtu register slave; no dependencies
package mrs_pkg;

    localparam int RX_DEPTH       = 64;
    localparam int MEM_BYTES      = 512;
    localparam int MAX_DATA_BYTES = 56;

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int MEM_AW = $clog2(MEM_BYTES);

    localparam logic [7:0]  FUNC_READ_HOLD  = 8'h03;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  FUNC_PRESET     = 8'h06;
    localparam logic [7:0]  FUNC_WRITE_MULT = 8'h10;

    localparam logic [15:0] WORD_BASE  = 16'h0100;
    localparam logic [15:0] FLOAT_BASE = 16'h0200;
    localparam logic [15:0] PRESET_MASK = 16'h00FF;
    localparam logic [7:0]  COUNT_MASK  = 8'h7F;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam int MIN_FRAME = 7;
    localparam logic [3:0] SILENCE_MAX = 4'hF;

    localparam logic [2:0] CFG_UNIT_ID = 3'd0;
    localparam logic [2:0] CFG_GAP     = 3'd4;

    typedef enum logic [1:0] {
        REGION_BYTE,
        REGION_WORD,
        REGION_FLOAT
    } region_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_WT,
        ST_CHECK,
        ST_ERR,
        ST_PRESET,
        ST_WR_RD,
        ST_WR_WT,
        ST_WR_MEM,
        ST_ECHO,
        ST_RHDR,
        ST_RD_RD,
        ST_RD_WT,
        ST_RDATA,
        ST_CRC
    } state_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/modbus_rtu_register_slave.sv
// modbus_rtu_register_slave: frame buffer, register memory and the frame sequencer
// depends on mrs_pkg
//
// usage
//   s_ channel: one beat per received uart byte (s_tuser = 0, byte in s_tdata) or
//   one silence timer tick (s_tuser = 1). a tick ends the frame once at least
//   seven bytes arrived and the silent tick count reaches gap_limit.
//   m_ channel: response bytes in line order, crc closing the frame, m_tlast on
//   the final beat; a bad crc or a foreign address gives a single beat with
//   m_tuser[0] set. m_tuser[1] marks every beat of a write-multiple reply.
//   apb port: unit_id at byte address 0, gap_limit at 4; these must be written
//   only when idle, a rule for the user that the block does not enforce.
// operation
//   byte and tick beats are taken while idle; a frame-ending tick starts the
//   sequencer: a crc scan of the buffered bytes over one registered read port,
//   then memory writes or reads and the reply bytes; s_tready is low meanwhile.
// reset
//   aresetn clears control state and starts a pass that zeroes the register
//   memory; no beat is taken until it ends. apb writes are always taken.
// stall
//   results sit in one output register; a stalled m_ side only holds the
//   sequencer at its next emitted byte, and idle byte beats keep flowing.
module modbus_rtu_register_slave (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] command
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic [1:0] m_tuser,   // [0] kind, [1] dirty
    output logic       m_tlast,
    // apb configuration
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import mrs_pkg::*;

    // configuration
    logic [7:0] unit_id_reg;
    logic [3:0] gap_reg;

    // sequencer state
    state_t state_reg, state_next;
    logic [MEM_AW-1:0] clr_reg;
    logic [RX_AW-1:0]  fill_reg;
    logic [3:0]        silence_reg;
    logic [RX_AW-1:0]  n_reg;
    logic [RX_AW-1:0]  idx_reg;
    logic [7:0]        hdr_reg [MIN_FRAME];
    logic [15:0]       rcrc_reg;
    logic [15:0]       crc_reg;
    logic [8:0]        x_reg;
    logic [1:0]        j_reg;
    logic [RX_AW-1:0]  ri_reg;
    logic [7:0]        cnt_reg;
    logic [MEM_AW-1:0] base_reg;
    region_t           region_reg;
    logic              dirty_reg;
    logic [7:0]        g_reg [4];

    // output register
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic       m_tlast_reg;

    // memories
    logic [7:0] rx_mem  [RX_DEPTH];
    logic [7:0] reg_mem [MEM_BYTES];
    logic [7:0] buf_q, mem_q;
    logic              buf_we;
    logic [RX_AW-1:0]  buf_waddr, buf_raddr;
    logic [7:0]        buf_wdata;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    // derived control
    logic       in_fire, tick_fire, byte_fire, frame_end;
    logic       emit_ok, emit_valid, emit_fire, emit_kind, emit_last;
    logic [7:0] emit_byte;
    logic [1:0] grp_last;
    logic [15:0] off;
    logic [9:0]  buf_idx;
    logic [9:0]  x_plus_j;
    logic        hdr_bad, cnt_done, data_more;
    logic [7:0]  wr_byte, rd_byte;
    logic [7:0]  read_cnt;
    logic [MEM_AW-1:0] base_calc;
    logic [16:0] base_wide;

    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? {28'd0, gap_reg} : {24'd0, unit_id_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign tick_fire = in_fire && s_tuser;
    assign byte_fire = in_fire && !s_tuser;
    assign frame_end = tick_fire && (fill_reg >= RX_AW'(MIN_FRAME)) && (silence_reg >= gap_reg);
    assign emit_ok   = !m_tvalid_reg || m_tready;
    assign emit_fire = emit_valid && emit_ok;

    assign off       = {hdr_reg[2], hdr_reg[3]};
    assign grp_last  = (region_reg == REGION_FLOAT) ? 2'd3 :
                       (region_reg == REGION_WORD)  ? 2'd1 : 2'd0;
    assign buf_idx   = {1'b0, x_reg} + 10'd7 + {8'd0, j_reg};
    assign x_plus_j  = {1'b0, x_reg} + {8'd0, j_reg};
    assign hdr_bad   = ((hdr_reg[0] != 8'h00) && (hdr_reg[0] != unit_id_reg))
                       || (crc_reg != rcrc_reg);
    assign cnt_done  = (x_reg >= {1'b0, cnt_reg});
    assign data_more = (x_plus_j + 10'd1) < {2'b00, cnt_reg};

    // region base address, wrapped to the memory size
    always_comb begin
        if (hdr_reg[1] == FUNC_PRESET) begin
            base_wide = {(off & PRESET_MASK), 1'b0};
        end else if (off >= FLOAT_BASE) begin
            base_wide = {(off - FLOAT_BASE), 1'b0};
        end else if (off >= WORD_BASE) begin
            base_wide = {(off - WORD_BASE), 1'b0};
        end else begin
            base_wide = {1'b0, off};
        end
        base_calc = base_wide[MEM_AW-1:0];
    end

    // read byte count: doubled for the word and float regions, saturated
    always_comb begin
        logic [7:0] c;
        c = hdr_reg[5] & COUNT_MASK;
        if (off >= WORD_BASE) begin
            c = {c[6:0], 1'b0};
        end
        read_cnt = (c > 8'(MAX_DATA_BYTES)) ? 8'(MAX_DATA_BYTES) : c;
    end

    // stored byte to write for group position j
    always_comb begin
        case (region_reg)
            REGION_FLOAT: begin
                case (j_reg)
                    2'd0:    wr_byte = g_reg[1];
                    2'd1:    wr_byte = g_reg[0];
                    2'd2:    wr_byte = {g_reg[2][7], g_reg[3][6:0]};
                    default: wr_byte = {g_reg[2][6:0], g_reg[3][7]};
                endcase
            end
            REGION_WORD: wr_byte = j_reg[0] ? g_reg[0] : g_reg[1];
            default:     wr_byte = g_reg[0];
        endcase
    end

    // line byte to send for group position j
    always_comb begin
        case (region_reg)
            REGION_FLOAT: begin
                case (j_reg)
                    2'd0:    rd_byte = g_reg[1];
                    2'd1:    rd_byte = g_reg[0];
                    2'd2:    rd_byte = {g_reg[2][7], g_reg[3][7:1]};
                    default: rd_byte = {g_reg[3][0], g_reg[2][6:0]};
                endcase
            end
            REGION_WORD: rd_byte = j_reg[0] ? g_reg[0] : g_reg[1];
            default:     rd_byte = g_reg[0];
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == MEM_AW'(MEM_BYTES - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (frame_end) state_next = ST_SCAN_RD;
            ST_SCAN_RD: state_next = ST_SCAN_WT;
            ST_SCAN_WT: state_next = (idx_reg == n_reg - RX_AW'(1)) ? ST_CHECK : ST_SCAN_RD;
            ST_CHECK: begin
                if (hdr_bad) begin
                    state_next = ST_ERR;
                end else begin
                    case (hdr_reg[1])
                        FUNC_PRESET:                     state_next = ST_PRESET;
                        FUNC_WRITE_MULT:                 state_next = ST_WR_RD;
                        FUNC_READ_HOLD, FUNC_READ_INPUT: state_next = ST_RHDR;
                        default:                         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ERR:     if (emit_ok) state_next = ST_IDLE;
            ST_PRESET:  if (j_reg == 2'd1) state_next = ST_ECHO;
            ST_WR_RD:   state_next = (j_reg == 2'd0 && cnt_done) ? ST_ECHO : ST_WR_WT;
            ST_WR_WT:   state_next = (j_reg == grp_last) ? ST_WR_MEM : ST_WR_RD;
            ST_WR_MEM:  if (j_reg == grp_last) state_next = ST_WR_RD;
            ST_ECHO:    if (emit_ok && ri_reg == RX_AW'(5)) state_next = ST_CRC;
            ST_RHDR:    if (emit_ok && ri_reg == RX_AW'(2)) state_next = ST_RD_RD;
            ST_RD_RD:   state_next = (j_reg == 2'd0 && cnt_done) ? ST_CRC : ST_RD_WT;
            ST_RD_WT:   state_next = (j_reg == grp_last) ? ST_RDATA : ST_RD_RD;
            ST_RDATA:   if (emit_ok && (j_reg == grp_last || !data_more)) state_next = ST_RD_RD;
            ST_CRC:     if (emit_ok && j_reg == 2'd1) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory ports and emitted byte
    always_comb begin
        buf_we     = 1'b0;
        buf_waddr  = fill_reg;
        buf_wdata  = s_tdata;
        buf_raddr  = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = base_reg + MEM_AW'(x_plus_j);
        mem_wdata  = wr_byte;
        mem_raddr  = base_reg + MEM_AW'(x_plus_j);
        emit_valid = 1'b0;
        emit_byte  = 8'h00;
        emit_kind  = 1'b0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'h00;
            end
            ST_IDLE: buf_we = byte_fire;
            ST_WR_RD: buf_raddr = buf_idx[RX_AW-1:0];
            ST_WR_MEM: mem_we = 1'b1;
            ST_PRESET: begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + MEM_AW'(j_reg);
                mem_wdata = j_reg[0] ? hdr_reg[4] : hdr_reg[5];
            end
            ST_ERR: begin
                emit_valid = 1'b1;
                emit_kind  = 1'b1;
                emit_last  = 1'b1;
            end
            ST_ECHO: begin
                emit_valid = 1'b1;
                emit_byte  = (ri_reg == '0) ? unit_id_reg : hdr_reg[ri_reg[2:0]];
            end
            ST_RHDR: begin
                emit_valid = 1'b1;
                case (ri_reg[1:0])
                    2'd0:    emit_byte = unit_id_reg;
                    2'd1:    emit_byte = hdr_reg[1];
                    default: emit_byte = cnt_reg;
                endcase
            end
            ST_RDATA: begin
                emit_valid = 1'b1;
                emit_byte  = rd_byte;
            end
            ST_CRC: begin
                emit_valid = 1'b1;
                emit_byte  = j_reg[0] ? crc_reg[15:8] : crc_reg[7:0];
                emit_last  = j_reg[0];
            end
            default: ;
        endcase
        // response bytes replace the request in the frame buffer
        if (emit_valid && emit_ok && !emit_kind) begin
            buf_we    = 1'b1;
            buf_waddr = ri_reg;
            buf_wdata = emit_byte;
        end
    end

    // frame buffer
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            rx_mem[buf_waddr] <= buf_wdata;
        end
        buf_q <= rx_mem[buf_raddr];
    end

    // register memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            reg_mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= reg_mem[mem_raddr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_id_reg <= 8'd1;
            gap_reg     <= 4'd1;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CFG_GAP[2]) begin
                gap_reg <= pwdata[3:0];
            end else begin
                unit_id_reg <= pwdata[7:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (emit_fire) begin
            m_tdata_reg <= emit_byte;
            m_tuser_reg <= {dirty_reg && !emit_kind, emit_kind};
            m_tlast_reg <= emit_last;
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            fill_reg    <= '0;
            silence_reg <= '0;
            idx_reg     <= '0;
            x_reg       <= '0;
            j_reg       <= '0;
            ri_reg      <= '0;
            dirty_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + MEM_AW'(1);
                ST_IDLE: begin
                    if (byte_fire) begin
                        if (fill_reg != RX_AW'(RX_DEPTH - 1)) begin
                            fill_reg <= fill_reg + RX_AW'(1);
                        end
                        silence_reg <= '0;
                    end else if (frame_end) begin
                        n_reg       <= fill_reg;
                        fill_reg    <= '0;
                        silence_reg <= '0;
                        idx_reg     <= '0;
                        crc_reg     <= CRC_INIT;
                    end else if (tick_fire && silence_reg != SILENCE_MAX) begin
                        silence_reg <= silence_reg + 4'd1;
                    end
                end
                ST_SCAN_RD: ;
                ST_SCAN_WT: begin
                    if (idx_reg < n_reg - RX_AW'(2)) begin
                        crc_reg <= crc_step(crc_reg, buf_q);
                    end
                    if (idx_reg < RX_AW'(MIN_FRAME)) begin
                        hdr_reg[idx_reg[2:0]] <= buf_q;
                    end
                    if (idx_reg == n_reg - RX_AW'(2)) begin
                        rcrc_reg[7:0] <= buf_q;
                    end
                    if (idx_reg == n_reg - RX_AW'(1)) begin
                        rcrc_reg[15:8] <= buf_q;
                    end
                    idx_reg <= idx_reg + RX_AW'(1);
                end
                ST_CHECK: begin
                    base_reg  <= base_calc;
                    x_reg     <= '0;
                    j_reg     <= '0;
                    ri_reg    <= '0;
                    dirty_reg <= (hdr_reg[1] == FUNC_WRITE_MULT);
                    if (off >= FLOAT_BASE) begin
                        region_reg <= REGION_FLOAT;
                    end else if (off >= WORD_BASE) begin
                        region_reg <= REGION_WORD;
                    end else begin
                        region_reg <= REGION_BYTE;
                    end
                    cnt_reg <= (hdr_reg[1] == FUNC_WRITE_MULT) ? hdr_reg[6] : read_cnt;
                end
                ST_ERR: dirty_reg <= 1'b0;
                ST_PRESET: begin
                    if (j_reg == 2'd1) begin
                        j_reg   <= '0;
                        crc_reg <= CRC_INIT;
                    end else begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                ST_WR_RD: begin
                    if (j_reg == 2'd0 && cnt_done) begin
                        crc_reg <= CRC_INIT;
                    end
                end
                ST_WR_WT: begin
                    g_reg[j_reg] <= buf_q;
                    j_reg <= (j_reg == grp_last) ? 2'd0 : j_reg + 2'd1;
                end
                ST_WR_MEM: begin
                    if (j_reg == grp_last) begin
                        j_reg <= '0;
                        x_reg <= x_reg + 9'({1'b0, grp_last}) + 9'd1;
                    end else begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                ST_ECHO, ST_RHDR: begin
                    if (emit_ok) begin
                        // a read reply starts its crc at the first header byte
                        if (state_reg == ST_RHDR && ri_reg == RX_AW'(0)) begin
                            crc_reg <= crc_step(CRC_INIT, emit_byte);
                        end else begin
                            crc_reg <= crc_step(crc_reg, emit_byte);
                        end
                        ri_reg  <= ri_reg + RX_AW'(1);
                    end
                end
                ST_RD_RD: ;
                ST_RD_WT: begin
                    g_reg[j_reg] <= mem_q;
                    j_reg <= (j_reg == grp_last) ? 2'd0 : j_reg + 2'd1;
                end
                ST_RDATA: begin
                    if (emit_ok) begin
                        crc_reg <= crc_step(crc_reg, emit_byte);
                        ri_reg  <= ri_reg + RX_AW'(1);
                        if (j_reg == grp_last || !data_more) begin
                            j_reg <= '0;
                            x_reg <= x_reg + 9'({1'b0, grp_last}) + 9'd1;
                        end else begin
                            j_reg <= j_reg + 2'd1;
                        end
                    end
                end
                ST_CRC: begin
                    if (emit_ok) begin
                        ri_reg <= ri_reg + RX_AW'(1);
                        j_reg  <= j_reg[0] ? 2'd0 : 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // no beat is taken before the register memory is cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during memory clear");

    // a result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("pending result lost");

    // a frame under way always holds a full minimum frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (n_reg >= RX_AW'(MIN_FRAME)))
        else $error("short frame processed");

    // responses stay within the frame buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |-> (ri_reg <= RX_AW'(MAX_DATA_BYTES + 4)))
        else $error("response index too large");

endmodule
